// ===== sv/afsk_du_pkg.sv =====
package afsk_du_pkg;

  // Default stream and modem settings
  localparam int unsigned AFSK_SAMPLE_RATE = 16000;
  localparam int unsigned AFSK_BAUD_RATE   = 1200;
  localparam int unsigned AFSK_DELAY_TAPS  = 7;

  // Rate correction width; covers +-(32768/50) for every allowed rate pair
  localparam int unsigned RC_W = 12;

  // Deframer bit position codes
  localparam logic [3:0] BIT_HUNT = 4'd15;
  localparam logic [3:0] BIT_STOP = 4'd8;

  // Pipeline handshake control shared by all stages
  typedef struct packed {
    logic adv;   // all stages move one step
    logic take;  // an input transaction enters stage one
  } pipe_ctl_t;

  // Front end output: one tone decision per sample
  typedef struct packed {
    logic        vld;
    logic        dec;
    logic [14:0] peak;
    logic        blk;
  } front_out_t;

  // One result transaction
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [14:0] signal_peak;
    logic        block_done;
  } result_t;

endpackage

// ===== sv/afsk_du_in_if.sv =====
interface afsk_du_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               block_end;

  modport source (output valid, output sample, output block_end, input ready);
  modport sink (input valid, input sample, input block_end, output ready);
endinterface

// ===== sv/afsk_du_out_if.sv =====
interface afsk_du_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic [14:0] signal_peak;
  logic        block_done;

  modport source (output valid, output byte_valid, output data_byte, output signal_peak,
                  output block_done, input ready);
  modport sink (input valid, input byte_valid, input data_byte, input signal_peak,
                input block_done, output ready);
endinterface

// ===== sv/afsk_du_front.sv =====
module afsk_du_front import afsk_du_pkg::*; #(
  parameter int unsigned DELAY_TAPS = AFSK_DELAY_TAPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctl_t          ctl_i,
  input  logic signed [15:0] sample_i,
  input  logic               block_end_i,
  output front_out_t         front_o
);

  // Stage one state: DC block and peak meter
  logic signed [15:0] x1_q;
  logic signed [20:0] hp_q;
  logic [14:0]        peak_q;

  // Stage one pipeline register
  logic               v1_q;
  logic signed [15:0] s1_q;
  logic [14:0]        pk1_q;
  logic               bk1_q;

  // Stage two state and pipeline register
  logic signed [15:0] dl_q [DELAY_TAPS];
  logic               v2_q;
  logic signed [23:0] pr2_q;
  logic [14:0]        pk2_q;
  logic               bk2_q;

  // Stage three state and pipeline register
  logic signed [23:0] pa_q;
  logic               v3_q;
  logic               dec3_q;
  logic [14:0]        pk3_q;
  logic               bk3_q;

  logic signed [22:0] y_full;
  logic signed [20:0] y;
  logic signed [15:0] s_d;
  logic signed [16:0] abs17;
  logic [14:0]        mag;
  logic [14:0]        peak_d;
  logic signed [31:0] prod32;
  logic signed [24:0] diff25;
  logic signed [24:0] avg25;
  logic signed [23:0] pa_d;

  // DC block, saturate, peak meter
  always_comb begin
    y_full = 23'(sample_i) - 23'(x1_q) + 23'(hp_q) - 23'(hp_q >>> 3);
    y      = y_full[20:0];
    if (y > 21'sd32767) begin
      s_d = 16'sh7FFF;
    end else if (y < -21'sd32768) begin
      s_d = 16'sh8000;
    end else begin
      s_d = y[15:0];
    end
    abs17 = s_d[15] ? -17'(s_d) : 17'(s_d);
    mag   = (abs17 > 17'sd32767) ? 15'h7FFF : abs17[14:0];
    if (mag > peak_q) begin
      peak_d = mag;
    end else if (peak_q != '0) begin
      peak_d = peak_q - ((peak_q >> 10) + 15'd1);
    end else begin
      peak_d = peak_q;
    end
  end

  // Delayed product and first-order average
  always_comb begin
    prod32 = s1_q * dl_q[DELAY_TAPS-1];
    diff25 = 25'(pr2_q) - 25'(pa_q);
    avg25  = 25'(pa_q) + (diff25 >>> 3);
    pa_d   = avg25[23:0];
  end

  // Advance state and pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q   <= '0;
      hp_q   <= '0;
      peak_q <= '0;
      pa_q   <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      for (int i = 0; i < DELAY_TAPS; i++) begin
        dl_q[i] <= '0;
      end
    end else if (ctl_i.adv) begin
      v1_q <= ctl_i.take;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (ctl_i.take) begin
        x1_q   <= sample_i;
        hp_q   <= y;
        peak_q <= peak_d;
      end
      if (v1_q) begin
        dl_q[0] <= s1_q;
        for (int i = 1; i < DELAY_TAPS; i++) begin
          dl_q[i] <= dl_q[i-1];
        end
      end
      if (v2_q) begin
        pa_q <= pa_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      s1_q   <= s_d;
      pk1_q  <= peak_d;
      bk1_q  <= block_end_i;
      pr2_q  <= prod32[31:8];
      pk2_q  <= pk1_q;
      bk2_q  <= bk1_q;
      dec3_q <= pa_d[23];
      pk3_q  <= pk2_q;
      bk3_q  <= bk2_q;
    end
  end

  assign front_o = '{vld: v3_q, dec: dec3_q, peak: pk3_q, blk: bk3_q};

endmodule

// ===== sv/afsk_du_sync.sv =====
module afsk_du_sync import afsk_du_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = AFSK_SAMPLE_RATE,
  parameter int unsigned BAUD_RATE   = AFSK_BAUD_RATE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctl_t  ctl_i,
  input  front_out_t front_i,
  output result_t    result_o
);

  localparam int unsigned PhInc     = (BAUD_RATE * 65536) / SAMPLE_RATE;
  localparam int unsigned RateLimit = PhInc / 50;
  localparam logic signed [13:0] RcMax = 14'(RateLimit);
  localparam logic signed [13:0] RcMin = -14'(RateLimit);

  logic [15:0]            bp_q, bp_d;
  logic signed [RC_W-1:0] rc_q, rc_d;
  logic                   last_q, last_d;
  logic [7:0]             ones_q, ones_d;
  logic [7:0]             cnt_q, cnt_d;
  logic [3:0]             pos_q, pos_d;
  logic [7:0]             sh_q, sh_d;

  logic [15:0]        ph_add;
  logic signed [16:0] ph17;
  logic signed [16:0] adj;
  logic signed [16:0] corr;
  logic signed [13:0] rc_wide;
  logic               in_win;
  logic               bit_v;
  logic               byte_ok;

  // Bit PLL: advance phase, pull toward each tone transition
  always_comb begin
    ph_add  = bp_q + 16'(PhInc) + 16'(rc_q);
    ph17    = (ph_add > 16'h8000) ? $signed({1'b1, ph_add}) : $signed({1'b0, ph_add});
    adj     = ph17 >>> 2;
    corr    = ph17 >>> 8;
    rc_wide = 14'(rc_q) - 14'(corr);
    bp_d    = ph_add;
    rc_d    = rc_q;
    last_d  = last_q;
    if (front_i.dec != last_q) begin
      bp_d   = ph_add - adj[15:0];
      last_d = front_i.dec;
      if (rc_wide > RcMax) begin
        rc_d = RC_W'(RcMax);
      end else if (rc_wide < RcMin) begin
        rc_d = RC_W'(RcMin);
      end else begin
        rc_d = rc_wide[RC_W-1:0];
      end
    end
  end

  // Majority vote over the middle half of the bit, then deframe
  always_comb begin
    ones_d  = ones_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    sh_d    = sh_q;
    byte_ok = 1'b0;
    if (bp_q[15:14] == 2'b00 && bp_d[15:14] != 2'b00) begin
      ones_d = '0;
      cnt_d  = '0;
    end
    in_win = (bp_d[15:14] == 2'b01) || (bp_d[15:14] == 2'b10);
    if (in_win) begin
      if (front_i.dec && ones_d != 8'hFF) begin
        ones_d = ones_d + 8'd1;
      end
      if (cnt_d != 8'hFF) begin
        cnt_d = cnt_d + 8'd1;
      end
    end
    bit_v = (cnt_d != '0) && ({ones_d, 1'b0} >= {1'b0, cnt_d});
    if (bp_q[15:14] != 2'b11 && bp_d[15:14] == 2'b11) begin
      if (pos_q == BIT_HUNT) begin
        if (!bit_v) begin
          pos_d = '0;
          sh_d  = '0;
        end
      end else if (pos_q < BIT_STOP) begin
        sh_d[pos_q[2:0]] = bit_v;
        pos_d            = pos_q + 4'd1;
      end else begin
        byte_ok = bit_v;
        pos_d   = BIT_HUNT;
      end
    end
  end

  // Hold state between samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q   <= '0;
      rc_q   <= '0;
      last_q <= 1'b1;
      ones_q <= '0;
      cnt_q  <= '0;
      pos_q  <= BIT_HUNT;
      sh_q   <= '0;
    end else if (ctl_i.adv && front_i.vld) begin
      bp_q   <= bp_d;
      rc_q   <= rc_d;
      last_q <= last_d;
      ones_q <= ones_d;
      cnt_q  <= cnt_d;
      pos_q  <= pos_d;
      sh_q   <= sh_d;
    end
  end

  assign result_o = '{byte_valid:  byte_ok,
                      data_byte:   byte_ok ? sh_q : 8'h00,
                      signal_peak: front_i.peak,
                      block_done:  front_i.blk};

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (14'(rc_q) <= RcMax) && (14'(rc_q) >= RcMin))
    else $error("rate correction outside its clamp");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == BIT_HUNT) || (pos_q <= BIT_STOP))
    else $error("deframer bit position out of range");

  a_byte_at_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_i.vld && byte_ok |-> pos_q == BIT_STOP)
    else $error("byte delivered outside the stop bit");

endmodule

// ===== sv/afsk_demodulator_uart_top.sv =====
// Bell 202 style AFSK receiver: one signed 16-bit audio sample per input transaction, one
// result transaction per sample carrying the peak level and, when a stop bit closes an 8N1
// frame, the received byte. The block takes a sample every clock cycle while the output is
// not stalled; each result is registered through four register stages (DC block and
// peak meter, delayed product, product average, bit PLL with deframer into the output
// register), the first of which loads on the accepting edge. The input stalls only while a
// finished result sits in the output register and is not taken. Back-pressure stalls the whole
// pipeline, so no byte is ever dropped; block_end travels through as block_done.
module afsk_demodulator_uart_top import afsk_du_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = AFSK_SAMPLE_RATE,
  parameter int unsigned BAUD_RATE   = AFSK_BAUD_RATE,
  parameter int unsigned DELAY_TAPS  = AFSK_DELAY_TAPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  afsk_du_in_if.sink           sample_i,
  afsk_du_out_if.source        result_o
);

  pipe_ctl_t  ctl;
  front_out_t front;
  result_t    res_d, res_q;
  logic       ovld_q;

  // Advance whenever the output register is free or being emptied
  assign ctl.adv  = !ovld_q || result_o.ready;
  assign ctl.take = sample_i.valid && ctl.adv;
  assign sample_i.ready = ctl.adv;

  afsk_du_front #(
    .DELAY_TAPS (DELAY_TAPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sample_i    (sample_i.sample),
    .block_end_i (sample_i.block_end),
    .front_o     (front)
  );

  afsk_du_sync #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .BAUD_RATE   (BAUD_RATE)
  ) u_sync (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .front_i  (front),
    .result_o (res_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (ctl.adv) begin
      ovld_q <= front.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = ovld_q;
  assign result_o.byte_valid  = res_q.byte_valid;
  assign result_o.data_byte   = res_q.data_byte;
  assign result_o.signal_peak = res_q.signal_peak;
  assign result_o.block_done  = res_q.block_done;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovld_q |-> sample_i.ready)
    else $error("input stalled with an empty output register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> result_o.valid && !result_o.ready)
    else $error("input stalled without a blocked result");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.byte_valid |-> result_o.data_byte == 8'h00)
    else $error("data byte not cleared without a byte");

endmodule
